/* design/apt_pkg.sv */
// shared types and constants for the affine point transform
package apt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int ROWS          = 3;
   localparam int COLS          = 4;
   localparam int PROD_W        = 2 * DATA_W;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_XFORM = 1'b1;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   typedef struct packed {
      logic load;
      logic valid;
   } out_ctl_type;

endpackage

/* design/apt_chan_if.sv */
// request and response channel interfaces
interface apt_req_if;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [1:0]           entry_row;
   logic [1:0]           entry_col;
   apt_pkg::word_type    entry_value;
   apt_pkg::word_type    point_x;
   apt_pkg::word_type    point_y;
   apt_pkg::word_type    point_z;

   modport source (output valid, action, entry_row, entry_col, entry_value,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, action, entry_row, entry_col, entry_value,
                   point_x, point_y, point_z, output ready);
endinterface

interface apt_rsp_if;
   logic                 valid;
   logic                 ready;
   apt_pkg::word_type    out_x;
   apt_pkg::word_type    out_y;
   apt_pkg::word_type    out_z;
   logic                 clipped;

   modport source (output valid, out_x, out_y, out_z, clipped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

/* design/affine_point_transform_core.sv */
// top level: matrix store, pipeline control, three row lanes and merge
// Transforms a point by a 3x4 signed fixed-point matrix (identity after reset).
// A beat with action 0 writes one matrix entry (rows 0 to 2 only) and gives no
// response; a beat with action 1 presents one response beat after passing the
// three lane stages (multiply, partial sums, rescale and clamp) and the output
// register, the first of which loads at the edge that accepts it. One beat is
// accepted per cycle while the pipeline has room; each stage holds its data
// while the next is full, so input keeps flowing into empty stages while a
// response waits. A transform uses the matrix as it stands when the beat is
// accepted.
module affine_point_transform_core #(
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   apt_req_if.sink   req_if,
   apt_rsp_if.source rsp_if
);

   localparam apt_pkg::word_type ONE_V = apt_pkg::word_type'(1) <<< FRAC_BITS;

   apt_pkg::word_type    m_ff [apt_pkg::ROWS][apt_pkg::COLS];
   logic                 v1_ff, v2_ff, v3_ff;
   logic                 rdy1, rdy2, rdy3, en_out;
   logic                 req_acc;
   apt_pkg::stage_en_type lane_en;
   apt_pkg::out_ctl_type  out_ctl;
   apt_pkg::word_type    lane_result [apt_pkg::ROWS];
   logic                 lane_clip   [apt_pkg::ROWS];

   // a stage may load when it is empty or its contents move on
   assign en_out       = !rsp_if.valid || rsp_if.ready;
   assign rdy3         = !v3_ff || en_out;
   assign rdy2         = !v2_ff || rdy3;
   assign rdy1         = !v1_ff || rdy2;
   assign req_if.ready = rdy1;
   assign req_acc      = req_if.valid && req_if.ready;

   assign lane_en.s1 = req_acc && (req_if.action == apt_pkg::ACT_XFORM);
   assign lane_en.s2 = rdy2;
   assign lane_en.s3 = rdy3;
   assign out_ctl.load  = en_out;
   assign out_ctl.valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= lane_en.s1;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // matrix entries, row three writes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < apt_pkg::ROWS; r++) begin
            for (int c = 0; c < apt_pkg::COLS; c++) begin
               m_ff[r][c] <= (r == c) ? ONE_V : '0;
            end
         end
      end else if (req_acc && (req_if.action == apt_pkg::ACT_WRITE)
                   && (req_if.entry_row < 2'(apt_pkg::ROWS))) begin
         m_ff[req_if.entry_row][req_if.entry_col] <= req_if.entry_value;
      end
   end

   for (genvar r = 0; r < apt_pkg::ROWS; r++) begin : g_lane
      apt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .en     (lane_en),
         .coef   (m_ff[r]),
         .px     (req_if.point_x),
         .py     (req_if.point_y),
         .pz     (req_if.point_z),
         .result (lane_result[r]),
         .clip   (lane_clip[r])
      );
   end

   apt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctl         (out_ctl),
      .lane_result (lane_result),
      .lane_clip   (lane_clip),
      .valid       (rsp_if.valid),
      .out_x       (rsp_if.out_x),
      .out_y       (rsp_if.out_y),
      .out_z       (rsp_if.out_z),
      .clipped     (rsp_if.clipped)
   );

   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_if.action == apt_pkg::ACT_XFORM)) |=> v1_ff)
      else $error("transform beat did not enter the lanes");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_if.action == apt_pkg::ACT_WRITE)) |=> !v1_ff)
      else $error("matrix write started a response");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(v3_ff))
      else $error("response without a finished lane result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (v1_ff && v2_ff && v3_ff && rsp_if.valid))
      else $error("input stalled while the pipeline has room");

endmodule

/* design/apt_lane.sv */
// one matrix row lane: three products, partial sums, rescale and saturate
module apt_lane #(
   parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  apt_pkg::stage_en_type en,
   input  apt_pkg::word_type     coef [apt_pkg::COLS],
   input  apt_pkg::word_type     px,
   input  apt_pkg::word_type     py,
   input  apt_pkg::word_type     pz,
   output apt_pkg::word_type     result,
   output logic                  clip
);

   localparam int SUM_W = apt_pkg::PROD_W + 3;
   localparam logic signed [SUM_W-1:0] MAX_V =
      {{(SUM_W - apt_pkg::DATA_W + 1){1'b0}}, {(apt_pkg::DATA_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] MIN_V =
      {{(SUM_W - apt_pkg::DATA_W + 1){1'b1}}, {(apt_pkg::DATA_W - 1){1'b0}}};

   logic signed [apt_pkg::PROD_W-1:0] prod0_ff, prod1_ff, prod2_ff;
   apt_pkg::word_type                 trans_ff;
   logic signed [SUM_W-1:0]           pair_ff, pair_in;
   logic signed [SUM_W-1:0]           bias_ff, bias_in;
   logic signed [SUM_W-1:0]           total, scaled;
   apt_pkg::word_type                 result_ff, result_in;
   logic                              clip_ff, clip_in;

   // stage 1: products, translation captured with them
   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod0_ff <= coef[0] * px;
         prod1_ff <= coef[1] * py;
         prod2_ff <= coef[2] * pz;
         trans_ff <= coef[3];
      end
   end

   // stage 2: translation moved up to product scale so the floor stays exact
   always_comb begin
      pair_in = SUM_W'(prod0_ff) + SUM_W'(prod1_ff);
      bias_in = SUM_W'(prod2_ff) + (SUM_W'(trans_ff) <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         pair_ff <= pair_in;
         bias_ff <= bias_in;
      end
   end

   // stage 3: arithmetic shift floors, then clamp to 32 bits
   always_comb begin
      total  = pair_ff + bias_ff;
      scaled = total >>> FRAC_BITS;
      priority if (scaled > MAX_V) begin
         result_in = MAX_V[apt_pkg::DATA_W-1:0];
         clip_in   = 1'b1;
      end else if (scaled < MIN_V) begin
         result_in = MIN_V[apt_pkg::DATA_W-1:0];
         clip_in   = 1'b1;
      end else begin
         result_in = scaled[apt_pkg::DATA_W-1:0];
         clip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         result_ff <= result_in;
         clip_ff   <= clip_in;
      end
   end

   assign result = result_ff;
   assign clip   = clip_ff;

endmodule

/* design/apt_merge.sv */
// output register combining the three lanes into one response beat
module apt_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  apt_pkg::out_ctl_type ctl,
   input  apt_pkg::word_type    lane_result [apt_pkg::ROWS],
   input  logic                 lane_clip   [apt_pkg::ROWS],
   output logic                 valid,
   output apt_pkg::word_type    out_x,
   output apt_pkg::word_type    out_y,
   output apt_pkg::word_type    out_z,
   output logic                 clipped
);

   logic              valid_ff;
   apt_pkg::word_type x_ff, y_ff, z_ff;
   logic              clip_ff, clip_in;

   assign clip_in = lane_clip[0] | lane_clip[1] | lane_clip[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff    <= lane_result[0];
         y_ff    <= lane_result[1];
         z_ff    <= lane_result[2];
         clip_ff <= clip_in;
      end
   end

   assign valid   = valid_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;
   assign clipped = clip_ff;

endmodule

/* bench/tb_affine_point_transform_core.sv */
// testbench for the affine point transform core: queued beats, live matrix prediction, scoreboard
module tb_affine_point_transform_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = apt_pkg::FRAC_BITS_DEF;
   localparam int ROWS        = apt_pkg::ROWS;
   localparam int COLS        = apt_pkg::COLS;
   localparam int ITEM_COUNT  = 1850;
   localparam int TAIL_ITEMS  = 150;
   localparam int LONG_HOLD   = 80;
   localparam int HOLD_AFTER  = 400;
   localparam int WATCHDOG    = 2000;
   localparam int DRAIN_CYC   = 8;
   localparam apt_pkg::word_type W_MAX = 32'sh7fffffff;
   localparam apt_pkg::word_type W_MIN = 32'sh80000000;
   localparam apt_pkg::word_type ONE   = apt_pkg::word_type'(1 << FRAC);
   localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
   localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

   typedef struct {
      logic              action;
      logic [1:0]        entry_row;
      logic [1:0]        entry_col;
      apt_pkg::word_type entry_value;
      apt_pkg::word_type point_x;
      apt_pkg::word_type point_y;
      apt_pkg::word_type point_z;
   } req_beat_type;

   typedef struct {
      apt_pkg::word_type out_x;
      apt_pkg::word_type out_y;
      apt_pkg::word_type out_z;
      logic              clipped;
   } point_result_type;

   logic clock;
   logic reset;

   apt_req_if req_ch ();
   apt_rsp_if rsp_ch ();

   affine_point_transform_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   req_beat_type      pending_beats[$];
   req_beat_type      offered;
   point_result_type  expected_points[$];
   apt_pkg::word_type xform_matrix[ROWS][COLS];

   int          send_gap       = 0;
   int          send_gap_pct   = 15;
   int          stall_left     = 0;
   int          stall_pct      = 15;
   int          idle_cycles    = 0;
   int          mismatch_count = 0;
   int          total_beats    = 0;
   int unsigned beats_in       = 0;
   logic        tail_phase     = 1'b0;
   logic        long_hold_done = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic point_result_type transform_point(apt_pkg::word_type px,
                                                        apt_pkg::word_type py,
                                                        apt_pkg::word_type pz);
      point_result_type   res;
      apt_pkg::word_type  lane[ROWS];
      logic signed [79:0] acc;
      res.clipped = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
         // exact sum of products, then floor rescale and translation
         acc = xform_matrix[r][0] * px + xform_matrix[r][1] * py
               + xform_matrix[r][2] * pz;
         acc = (acc >>> FRAC) + xform_matrix[r][3];
         if (acc > SAT_HI) begin
            lane[r] = W_MAX;
            res.clipped = 1'b1;
         end else if (acc < SAT_LO) begin
            lane[r] = W_MIN;
            res.clipped = 1'b1;
         end else begin
            lane[r] = acc[31:0];
         end
      end
      res.out_x = lane[0];
      res.out_y = lane[1];
      res.out_z = lane[2];
      return res;
   endfunction

   task automatic load_identity();
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            xform_matrix[r][c] = (r == c) ? ONE : '0;
   endtask

   task automatic absorb_beat(req_beat_type b);
      if (b.action == apt_pkg::ACT_WRITE) begin
         // row three does not exist and is dropped
         if (b.entry_row < 2'(ROWS))
            xform_matrix[b.entry_row][b.entry_col] = b.entry_value;
      end else begin
         expected_points.push_back(transform_point(b.point_x, b.point_y, b.point_z));
      end
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic apt_pkg::word_type pick_word();
      int unsigned       sel;
      apt_pkg::word_type w;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         w = apt_pkg::word_type'($urandom_range(0, 8 << FRAC))
             - apt_pkg::word_type'(4 << FRAC);
      end else if (sel < 80) begin
         w = apt_pkg::word_type'($urandom);
      end else begin
         case ($urandom_range(0, 5))
            0:       w = W_MAX;
            1:       w = W_MIN;
            2:       w = '0;
            3:       w = -1;
            4:       w = ONE;
            default: w = -ONE;
         endcase
      end
      return w;
   endfunction

   task automatic queue_write(int row, int col, apt_pkg::word_type value);
      req_beat_type b;
      b.action      = apt_pkg::ACT_WRITE;
      b.entry_row   = row[1:0];
      b.entry_col   = col[1:0];
      b.entry_value = value;
      b.point_x     = apt_pkg::word_type'($urandom);
      b.point_y     = apt_pkg::word_type'($urandom);
      b.point_z     = apt_pkg::word_type'($urandom);
      pending_beats.push_back(b);
   endtask

   task automatic queue_point(apt_pkg::word_type x, apt_pkg::word_type y,
                              apt_pkg::word_type z);
      req_beat_type b;
      b.action      = apt_pkg::ACT_XFORM;
      b.entry_row   = 2'($urandom_range(0, 3));
      b.entry_col   = 2'($urandom_range(0, 3));
      b.entry_value = apt_pkg::word_type'($urandom);
      b.point_x     = x;
      b.point_y     = y;
      b.point_z     = z;
      pending_beats.push_back(b);
   endtask

   // ---------------------------------------------------------------- clock

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
         tail_phase   <= 1'b0;
         load_identity();
      end else begin
         tail_phase <= (pending_beats.size() < TAIL_ITEMS);
         if (req_ch.valid && req_ch.ready) begin
            absorb_beat(offered);
            beats_in <= beats_in + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap     <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               offered = pending_beats.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.action      <= offered.action;
               req_ch.entry_row   <= offered.entry_row;
               req_ch.entry_col   <= offered.entry_col;
               req_ch.entry_value <= offered.entry_value;
               req_ch.point_x     <= offered.point_x;
               req_ch.point_y     <= offered.point_y;
               req_ch.point_z     <= offered.point_z;
               if ($urandom_range(0, 99) == 0)
                  case ($urandom_range(0, 2))
                     0:       send_gap_pct <= 0;
                     1:       send_gap_pct <= 8;
                     default: send_gap_pct <= 35;
                  endcase
               // gap starts once this beat is taken
               if (pending_beats.size() >= TAIL_ITEMS && $urandom_range(0, 99) < send_gap_pct)
                  send_gap <= $urandom_range(1, 14);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (!long_hold_done && beats_in >= HOLD_AFTER) begin
         // long back-pressure so the pipeline fills and stalls the input
         rsp_ch.ready   <= 1'b0;
         stall_left     <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 13);
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 99) == 0)
            case ($urandom_range(0, 2))
               0:       stall_pct <= 0;
               1:       stall_pct <= 8;
               default: stall_pct <= 35;
            endcase
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : rsp_check
      point_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("response beat with no transform pending: x=%h y=%h z=%h clip=%b",
                                      rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.clipped));
         end else begin
            want = expected_points.pop_front();
            if (rsp_ch.out_x !== want.out_x || rsp_ch.out_y !== want.out_y ||
                rsp_ch.out_z !== want.out_z || rsp_ch.clipped !== want.clipped)
               report_mismatch($sformatf("expected x=%h y=%h z=%h clip=%b, got x=%h y=%h z=%h clip=%b",
                                         want.out_x, want.out_y, want.out_z, want.clipped,
                                         rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                                         rsp_ch.clipped));
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("FAIL affine_point_transform_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int sel;
      int n;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.action      = apt_pkg::ACT_WRITE;
      req_ch.entry_row   = '0;
      req_ch.entry_col   = '0;
      req_ch.entry_value = '0;
      req_ch.point_x     = '0;
      req_ch.point_y     = '0;
      req_ch.point_z     = '0;
      rsp_ch.ready       = 1'b0;

      // identity after reset, extremes pass straight through
      queue_point('0, '0, '0);
      queue_point(W_MAX, W_MIN, -1);
      queue_point(1, -1, ONE);
      // writes to the missing fourth row change nothing
      queue_write(3, 0, apt_pkg::word_type'(7 << FRAC));
      queue_write(3, 3, W_MIN);
      queue_point(apt_pkg::word_type'(5 << FRAC), apt_pkg::word_type'(6 << FRAC),
                  apt_pkg::word_type'(7 << FRAC));
      // saturation both ways
      queue_write(0, 0, W_MAX);
      queue_point(W_MAX, '0, '0);
      queue_point(W_MIN, '0, '0);
      // tiny negative product floors toward minus infinity
      queue_write(0, 0, 1);
      queue_point(-1, '0, '0);
      queue_point(1, '0, '0);
      // translation extremes and largest product
      queue_write(1, 3, W_MIN);
      queue_write(2, 2, W_MIN);
      queue_point('0, '0, W_MIN);
      queue_point('0, W_MIN, '0);
      queue_write(2, 3, W_MAX);
      queue_write(0, 3, -1);
      queue_write(1, 0, -ONE);
      queue_write(0, 1, apt_pkg::word_type'(1 << (FRAC - 1)));
      queue_write(1, 2, W_MAX);
      queue_point(W_MAX, W_MAX, W_MAX);
      queue_point(W_MIN, W_MIN, W_MIN);
      queue_point(apt_pkg::word_type'(3 << FRAC), -apt_pkg::word_type'(2 << FRAC), ONE);

      while (pending_beats.size() < ITEM_COUNT) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            // reload a near-identity matrix, off-diagonal entries between -1 and 1
            for (int r = 0; r < ROWS; r++)
               for (int c = 0; c < COLS; c++)
                  queue_write(r, c, (r == c) ? ONE
                                    : apt_pkg::word_type'($urandom_range(0, 2 << FRAC))
                                      - apt_pkg::word_type'(1 << FRAC));
         end else if (sel < 16) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               if ($urandom_range(0, 1))
                  queue_write($urandom_range(0, 3), $urandom_range(0, 3),
                              apt_pkg::word_type'($urandom));
               else
                  queue_point(apt_pkg::word_type'($urandom), apt_pkg::word_type'($urandom),
                              apt_pkg::word_type'($urandom));
         end else begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
               queue_write(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                           $urandom_range(0, 3), pick_word());
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               queue_point(pick_word(), pick_word(), pick_word());
         end
      end
      total_beats = pending_beats.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (beats_in != total_beats);
      do @(negedge clock); while (expected_points.size() != 0);
      repeat (DRAIN_CYC) @(negedge clock);

      if (expected_points.size() != 0)
         report_mismatch($sformatf("%0d transform results never arrived",
                                   expected_points.size()));
      if (mismatch_count == 0)
         $display("PASS affine_point_transform_core");
      else
         $display("FAIL affine_point_transform_core");
      $finish;
   end

endmodule
